[rtl/core/ghi_pkg.sv]
// shared types, constants and microprogram for the gyro heading integrator
package ghi_pkg;

   // field widths
   localparam int SAMPLE_W    = 8;
   localparam int TICK_W      = 8;
   localparam int OVF_FIELD_W = 16;
   localparam int MARGIN_W    = 5;
   localparam int GAIN_W      = 16;
   localparam int CODE_W      = 8;
   localparam int CSR_W       = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int ANGLE_W     = 48;
   localparam int STEP_W      = 4;
   localparam int RATE_W      = 3;
   localparam int QUAD_W      = 3;
   localparam int BIN_W       = 4;
   localparam int XI_W        = 9;
   localparam int X3_W        = 12;
   localparam int VBIN_W      = 10;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_MARGIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_POS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_NEG    = 2'd2;

   // register reset values
   localparam logic [MARGIN_W-1:0] MARGIN_RESET   = 5'd5;
   localparam logic [GAIN_W-1:0]   GAIN_POS_RESET = 16'd1874;
   localparam logic [GAIN_W-1:0]   GAIN_NEG_RESET = 16'd1954;

   // arithmetic constants
   localparam int TICK_SHIFT     = 6;
   localparam int GAIN_FRAC      = 16;
   localparam logic [RATE_W-1:0] RATE_SCALE = 3'd5;
   localparam int RATE_SHIFT     = 8;
   localparam int HALF_TURN_DEG  = 180;
   localparam int FULL_TURN_DEG  = 360;
   localparam int QUARTER_DEG    = 90;
   localparam int BIN_FRAC       = 3;
   localparam int RECIP_QUARTER  = 729;
   localparam int RECIP_BIN      = 1457;
   localparam int RECIP_SHIFT    = 16;

   localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
   localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

   // sector codes
   localparam logic [CODE_W-1:0] CODE_RESET      = 8'h40;
   localparam logic [CODE_W-1:0] CODE_MAX        = 8'h80;
   localparam logic [CODE_W-1:0] CODE_BIN_OFFSET = 8'h10;
   localparam logic [CODE_W-1:0] CODE_NONE       = 8'h00;

   typedef struct packed {
      logic [SAMPLE_W-1:0]    sample;
      logic [TICK_W-1:0]      tick_count;
      logic [OVF_FIELD_W-1:0] overflow_count;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0] heading_code;
      logic              calibrating;
   } rsp_type;

   typedef logic [STEP_W-1:0] step_type;

   typedef enum logic [3:0] {
      OP_WAIT,
      OP_NOP,
      OP_MUL_GAIN,
      OP_MUL_RATE,
      OP_ACCUM,
      OP_WRAP,
      OP_OFFSET,
      OP_QUAD,
      OP_CODE,
      OP_CALIB,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_NO_REF
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ucode_type;

   typedef struct packed {
      logic req_fire;
      logic out_full;
      logic no_ref;
   } seq_status_type;

   // program addresses
   localparam step_type STEP_WAIT  = 4'd0;
   localparam step_type STEP_CHECK = 4'd1;
   localparam step_type STEP_GAIN  = 4'd2;
   localparam step_type STEP_RATE  = 4'd3;
   localparam step_type STEP_ACCUM = 4'd4;
   localparam step_type STEP_WRAP  = 4'd5;
   localparam step_type STEP_OFFS  = 4'd6;
   localparam step_type STEP_QUAD  = 4'd7;
   localparam step_type STEP_CODE  = 4'd8;
   localparam step_type STEP_CALIB = 4'd9;
   localparam step_type STEP_EMIT  = 4'd10;
   localparam step_type STEP_LAST  = STEP_EMIT;

   // control store
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type word;
      unique case (step)
         STEP_WAIT:  word = '{OP_WAIT,     COND_NEXT,   STEP_WAIT};
         STEP_CHECK: word = '{OP_NOP,      COND_NO_REF, STEP_CALIB};
         STEP_GAIN:  word = '{OP_MUL_GAIN, COND_NEXT,   STEP_WAIT};
         STEP_RATE:  word = '{OP_MUL_RATE, COND_NEXT,   STEP_WAIT};
         STEP_ACCUM: word = '{OP_ACCUM,    COND_NEXT,   STEP_WAIT};
         STEP_WRAP:  word = '{OP_WRAP,     COND_NEXT,   STEP_WAIT};
         STEP_OFFS:  word = '{OP_OFFSET,   COND_NEXT,   STEP_WAIT};
         STEP_QUAD:  word = '{OP_QUAD,     COND_NEXT,   STEP_WAIT};
         STEP_CODE:  word = '{OP_CODE,     COND_ALWAYS, STEP_EMIT};
         STEP_CALIB: word = '{OP_CALIB,    COND_NEXT,   STEP_WAIT};
         STEP_EMIT:  word = '{OP_EMIT,     COND_ALWAYS, STEP_WAIT};
         default:    word = '{OP_NOP,      COND_ALWAYS, STEP_WAIT};
      endcase
      return word;
   endfunction

endpackage

[rtl/core/ghi_seq.sv]
// microprogram sequencer: step counter, control store and jump logic
module ghi_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  ghi_pkg::seq_status_type  status,
   output ghi_pkg::ucode_type       ctrl
);

   ghi_pkg::step_type step_ff;
   ghi_pkg::step_type step_in;
   logic              hold;
   logic              jump;

   assign ctrl = ghi_pkg::ucode_rom(step_ff);

   // wait and emit steps stall on their handshakes
   assign hold = ((ctrl.op == ghi_pkg::OP_WAIT) && !status.req_fire) ||
                 ((ctrl.op == ghi_pkg::OP_EMIT) && status.out_full);

   assign jump = (ctrl.cond == ghi_pkg::COND_ALWAYS) ||
                 ((ctrl.cond == ghi_pkg::COND_NO_REF) && status.no_ref);

   always_comb begin
      priority if (hold) begin
         step_in = step_ff;
      end else if (jump) begin
         step_in = ctrl.target;
      end else begin
         step_in = step_ff + ghi_pkg::step_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ghi_pkg::STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   a_step_in_program: assert property (@(posedge clock) disable iff (reset)
      step_ff <= ghi_pkg::STEP_LAST)
      else $error("step counter left the program");

   a_wait_holds: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == ghi_pkg::OP_WAIT) && !status.req_fire |=> ctrl.op == ghi_pkg::OP_WAIT)
      else $error("sequencer left wait without a word");

   a_emit_returns: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == ghi_pkg::OP_EMIT) && !status.out_full |=> step_ff == ghi_pkg::STEP_WAIT)
      else $error("emit did not return to wait");

endmodule

[rtl/core/gyro_heading_integrator_top.sv]
// top level of the gyro heading integrator: csr bank, datapath and output register
//
// Integrates 8-bit gyro samples into a 48-bit signed heading angle with
// ANGLE_FRAC_BITS fraction bits and reports a sector code per sample. The
// first word after reset is taken as the zero-rate reference and answered
// with the previous code and calibrating set. Each later word gives the rate
// trunc((sample-ref)*5/256), scaled by (tick_count + 64*overflow_count) and
// the gain for its sign, added with saturation, wrapped once by 360 degrees
// and coded. Control is a microprogram walked one step per cycle by a small
// sequencer, save where wait stalls for a word and emit for a full output;
// the datapath holds one 23x16 multiplier, a small rate multiply, a wide adder
// and two reciprocal multiplies for the quadrant and bin. An integration word
// walks check, gain, rate, accumulate, wrap, offset, quadrant, code and emit
// up to its result in the output register, a calibration word check, calibrate
// and emit; the next word is taken once the program is back at wait, even while
// the previous result sits in the output register. Registers must be written
// through the csr port only while the block is idle; nothing enforces it.
module gyro_heading_integrator_top #(
   parameter int ANGLE_FRAC_BITS = 16,
   parameter int OVERFLOW_BITS   = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // input words
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ghi_pkg::req_type                  req_data,
   // result words
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ghi_pkg::rsp_type                  rsp_data,
   // register writes
   input  logic                              csr_we,
   input  logic [ghi_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ghi_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int AW     = ghi_pkg::ANGLE_W;
   localparam int F      = ANGLE_FRAC_BITS;
   // only this many overflow bits count
   localparam int OVF_W  = (OVERFLOW_BITS < ghi_pkg::OVF_FIELD_W) ?
                           OVERFLOW_BITS : ghi_pkg::OVF_FIELD_W;
   localparam int ELAP_W = OVF_W + ghi_pkg::TICK_SHIFT + 1;
   localparam int P1_W   = ELAP_W + ghi_pkg::GAIN_W;
   localparam int MAG_W  = P1_W + ghi_pkg::RATE_W;
   // align gain fraction to the angle fraction
   localparam int SHL    = (F >= ghi_pkg::GAIN_FRAC) ? F - ghi_pkg::GAIN_FRAC : 0;
   localparam int SHR    = (F < ghi_pkg::GAIN_FRAC) ? ghi_pkg::GAIN_FRAC - F : 0;
   localparam int INC_W  = MAG_W + SHL;
   localparam int SUM_W  = ((INC_W > AW) ? INC_W : AW) + 2;
   localparam int XW     = AW + 1;
   localparam int QP_W   = ghi_pkg::XI_W + 10;
   localparam int BP_W   = ghi_pkg::VBIN_W + 11;

   localparam logic signed [AW-1:0] DEG360 =
      AW'(ghi_pkg::FULL_TURN_DEG) << ANGLE_FRAC_BITS;

   // sequencer
   ghi_pkg::ucode_type      ctrl;
   ghi_pkg::seq_status_type status;

   // config
   logic [ghi_pkg::MARGIN_W-1:0] margin_ff;
   logic [ghi_pkg::GAIN_W-1:0]   gain_pos_ff;
   logic [ghi_pkg::GAIN_W-1:0]   gain_neg_ff;

   // state
   logic                         ref_valid_ff;
   logic [ghi_pkg::SAMPLE_W-1:0] zero_ref_ff;
   logic signed [AW-1:0]         angle_ff;
   logic [ghi_pkg::CODE_W-1:0]   last_code_ff;

   // working registers
   ghi_pkg::req_type             in_ff;
   logic [P1_W-1:0]              prod_ff;
   logic [ghi_pkg::RATE_W-1:0]   rmag_ff;
   logic                         neg_ff;
   logic [MAG_W-1:0]             mag_ff;
   logic [XW-1:0]                x_ff;
   logic [ghi_pkg::QUAD_W-1:0]   q_ff;
   logic                         inrange_ff;
   logic                         cal_ff;
   logic                         rsp_valid_ff;
   ghi_pkg::rsp_type             rsp_data_ff;

   // handshakes
   logic req_fire;
   logic out_full;
   logic emit_go;

   assign req_ready = (ctrl.op == ghi_pkg::OP_WAIT);
   assign req_fire  = req_valid && req_ready;
   assign out_full  = rsp_valid_ff && !rsp_ready;
   assign emit_go   = (ctrl.op == ghi_pkg::OP_EMIT) && !out_full;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status = '{req_fire: req_fire, out_full: out_full, no_ref: !ref_valid_ff};

   ghi_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // rate and elapsed time
   logic [ghi_pkg::SAMPLE_W:0]   diff9;
   logic [ghi_pkg::SAMPLE_W-1:0] adiff;
   logic [10:0]                  rate_scaled;
   logic [ghi_pkg::RATE_W-1:0]   rmag_in;
   logic                         neg_in;
   logic [ELAP_W-1:0]            elapsed;
   logic [ghi_pkg::GAIN_W-1:0]   gain_sel;
   logic [P1_W-1:0]              prod_in;

   assign diff9 = {1'b0, in_ff.sample} - {1'b0, zero_ref_ff};
   assign adiff = diff9[ghi_pkg::SAMPLE_W] ? ghi_pkg::SAMPLE_W'(-diff9) :
                                             diff9[ghi_pkg::SAMPLE_W-1:0];
   // truncation toward zero; differences within one count give zero anyway
   assign rate_scaled = 11'(adiff) * 11'(ghi_pkg::RATE_SCALE);
   assign rmag_in     = rate_scaled[ghi_pkg::RATE_SHIFT +: ghi_pkg::RATE_W];
   assign neg_in      = diff9[ghi_pkg::SAMPLE_W] && (rmag_in != '0);
   assign elapsed     = ELAP_W'(in_ff.tick_count) +
                        (ELAP_W'(in_ff.overflow_count[OVF_W-1:0]) << ghi_pkg::TICK_SHIFT);
   assign gain_sel    = neg_in ? gain_neg_ff : gain_pos_ff;
   assign prod_in     = P1_W'(elapsed) * P1_W'(gain_sel);

   // accumulate with saturation
   logic [INC_W-1:0]        inc;
   logic signed [SUM_W-1:0] angle_ext;
   logic signed [SUM_W-1:0] inc_ext;
   logic signed [SUM_W-1:0] sum;
   logic [SUM_W-AW:0]       sum_top;
   logic signed [AW-1:0]    sat_in;

   assign inc       = (INC_W'(mag_ff) << SHL) >> SHR;
   assign angle_ext = {{(SUM_W-AW){angle_ff[AW-1]}}, angle_ff};
   assign inc_ext   = {{(SUM_W-INC_W){1'b0}}, inc};
   assign sum       = neg_ff ? angle_ext - inc_ext : angle_ext + inc_ext;
   assign sum_top   = sum[SUM_W-1:AW-1];

   always_comb begin
      priority if ((&sum_top) || !(|sum_top)) begin
         sat_in = sum[AW-1:0];
      end else if (sum[SUM_W-1]) begin
         sat_in = ghi_pkg::ANGLE_MIN;
      end else begin
         sat_in = ghi_pkg::ANGLE_MAX;
      end
   end

   // wrap once by a full turn
   logic [7:0]           half8;
   logic signed [AW-1:0] half_fx;
   logic signed [AW-1:0] wrap_in;

   assign half8   = 8'(ghi_pkg::HALF_TURN_DEG) + 8'(margin_ff);
   assign half_fx = AW'(half8) << ANGLE_FRAC_BITS;

   always_comb begin
      priority if (angle_ff < -half_fx) begin
         wrap_in = angle_ff + DEG360;
      end else if (angle_ff > half_fx) begin
         wrap_in = angle_ff - DEG360;
      end else begin
         wrap_in = angle_ff;
      end
   end

   // offset so the coded span starts at zero
   logic [XW-1:0] x_in;
   assign x_in = {angle_ff[AW-1], angle_ff} + {1'b0, half_fx};

   // quadrant via reciprocal of 90 on the integer degrees
   logic [ghi_pkg::XI_W-1:0]   xi;
   logic [QP_W-1:0]            quad_prod;
   logic [ghi_pkg::QUAD_W-1:0] q_in;
   logic [8:0]                 span9;
   logic [AW-1:0]              span_fx;
   logic                       inrange_in;

   assign xi         = x_ff[F +: ghi_pkg::XI_W];
   assign quad_prod  = QP_W'(xi) * QP_W'(ghi_pkg::RECIP_QUARTER);
   assign q_in       = quad_prod[ghi_pkg::RECIP_SHIFT +: ghi_pkg::QUAD_W];
   assign span9      = 9'(ghi_pkg::FULL_TURN_DEG) + {3'b000, margin_ff, 1'b0};
   assign span_fx    = AW'(span9) << ANGLE_FRAC_BITS;
   assign inrange_in = !x_ff[XW-1] && (x_ff[AW-1:0] < span_fx);

   // axis test and 5.625 degree bin
   logic [ghi_pkg::XI_W-1:0]   quad_base;
   logic [ghi_pkg::XI_W-1:0]   d9;
   logic                       on_axis;
   logic [ghi_pkg::X3_W-1:0]   x3;
   logic [ghi_pkg::X3_W-1:0]   v12;
   logic [BP_W-1:0]            bin_prod;
   logic [ghi_pkg::BIN_W-1:0]  bin;
   logic [ghi_pkg::CODE_W-1:0] region;
   logic [ghi_pkg::CODE_W-1:0] code_in;

   assign quad_base = ghi_pkg::XI_W'(q_ff) * ghi_pkg::XI_W'(ghi_pkg::QUARTER_DEG);
   assign d9        = xi - quad_base;
   assign on_axis   = d9 < {3'b000, margin_ff, 1'b0};
   assign x3        = x_ff[F-ghi_pkg::BIN_FRAC +: ghi_pkg::X3_W];
   assign v12       = x3 - {4'b0000, margin_ff, 3'b000} -
                      (ghi_pkg::X3_W'(quad_base) << ghi_pkg::BIN_FRAC);
   assign bin_prod  = BP_W'(v12[ghi_pkg::VBIN_W-1:0]) * BP_W'(ghi_pkg::RECIP_BIN);
   assign bin       = bin_prod[ghi_pkg::RECIP_SHIFT +: ghi_pkg::BIN_W];
   assign region    = {q_ff, 5'b00000};

   always_comb begin
      priority if (!inrange_ff) begin
         code_in = ghi_pkg::CODE_NONE;
      end else if (on_axis) begin
         code_in = region;
      end else begin
         code_in = region + ghi_pkg::CODE_BIN_OFFSET + {4'b0000, bin};
      end
   end

   // control state, config and integrator state
   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff    <= ghi_pkg::MARGIN_RESET;
         gain_pos_ff  <= ghi_pkg::GAIN_POS_RESET;
         gain_neg_ff  <= ghi_pkg::GAIN_NEG_RESET;
         ref_valid_ff <= 1'b0;
         angle_ff     <= '0;
         last_code_ff <= ghi_pkg::CODE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               ghi_pkg::CSR_AXIS_MARGIN: margin_ff   <= csr_wdata[ghi_pkg::MARGIN_W-1:0];
               ghi_pkg::CSR_GAIN_POS:    gain_pos_ff <= csr_wdata;
               ghi_pkg::CSR_GAIN_NEG:    gain_neg_ff <= csr_wdata;
               default: ;  // unused index, write dropped
            endcase
         end
         if (ctrl.op == ghi_pkg::OP_CALIB) begin
            ref_valid_ff <= 1'b1;
         end
         if (ctrl.op == ghi_pkg::OP_ACCUM) begin
            angle_ff <= sat_in;
         end else if (ctrl.op == ghi_pkg::OP_WRAP) begin
            angle_ff <= wrap_in;
         end
         if (ctrl.op == ghi_pkg::OP_CODE) begin
            last_code_ff <= code_in;
         end
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff <= req_data;
      end
      unique case (ctrl.op)
         ghi_pkg::OP_MUL_GAIN: begin
            prod_ff <= prod_in;
            rmag_ff <= rmag_in;
            neg_ff  <= neg_in;
         end
         ghi_pkg::OP_MUL_RATE: begin
            mag_ff <= MAG_W'(prod_ff) * MAG_W'(rmag_ff);
         end
         ghi_pkg::OP_OFFSET: begin
            x_ff <= x_in;
         end
         ghi_pkg::OP_QUAD: begin
            q_ff       <= q_in;
            inrange_ff <= inrange_in;
         end
         ghi_pkg::OP_CODE: begin
            cal_ff <= 1'b0;
         end
         ghi_pkg::OP_CALIB: begin
            zero_ref_ff <= in_ff.sample;
            cal_ff      <= 1'b1;
         end
         ghi_pkg::OP_EMIT: begin
            if (!out_full) begin
               rsp_data_ff <= '{heading_code: last_code_ff, calibrating: cal_ff};
            end
         end
         default: ;  // wait, check, accumulate and wrap touch no datapath register here
      endcase
   end

   a_code_in_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.heading_code <= ghi_pkg::CODE_MAX)
      else $error("sector code beyond last region");

   a_cal_sets_ref: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.calibrating |-> ref_valid_ff)
      else $error("calibration word out without reference");

   a_angle_moves_in_steps: assert property (@(posedge clock) disable iff (reset)
      !$stable(angle_ff) |-> $past(reset) ||
         $past(ctrl.op == ghi_pkg::OP_ACCUM) || $past(ctrl.op == ghi_pkg::OP_WRAP))
      else $error("heading changed outside accumulate or wrap");

endmodule
